@@ hw/rtl/run_length_decoder_defines.svh @@
// Assertion macros for the run-length decoder.
// Each macro expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef RUN_LENGTH_DECODER_DEFINES_SVH
`define RUN_LENGTH_DECODER_DEFINES_SVH

`ifndef ASSERT_OFF
`define RLD_ASSERT(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);
`define RLD_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`else
`define RLD_ASSERT(label, expr, msg)
`define RLD_ASSERT_IMPL(label, ante, cons, msg)
`endif

`endif

@@ hw/rtl/rld_pkg.sv @@
// Shared constants, codes and helpers for the run-length decoder.
// Used by run_length_decoder; depends on nothing else.
package rld_pkg;

	localparam int DEF_MAX_COUNT_BYTES  = 4;
	localparam int DEF_MAX_SYMBOL_BYTES = 4;

	localparam int CFG_W     = 3;
	localparam int CFG_IDX_W = 1;
	localparam int SIZE_W    = 5;

	localparam logic [CFG_IDX_W-1:0] REG_COUNT_BYTES  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_SYMBOL_BYTES = 1'b1;

	typedef enum logic {
		OP_FEED = 1'b0,
		OP_READ = 1'b1
	} opcode_t;

	typedef enum logic [1:0] {
		ST_ACCEPTED = 2'd0,
		ST_REFUSED  = 2'd1,
		ST_BYTE     = 2'd2,
		ST_NODATA   = 2'd3
	} status_t;

	// A size of zero acts as one, and a size above the limit acts as the limit.
	function automatic logic [SIZE_W-1:0] clamp_size(input logic [CFG_W-1:0] v, input int maxv);
		logic [SIZE_W-1:0] r;
		if (v == '0) begin
			r = SIZE_W'(1);
		end else if (SIZE_W'(v) > SIZE_W'(maxv)) begin
			r = SIZE_W'(maxv);
		end else begin
			r = SIZE_W'(v);
		end
		return r;
	endfunction

endpackage

@@ hw/rtl/run_length_decoder.sv @@
// Run-length decoder top level: input register, decode logic and result register.
// Depends on rld_pkg and run_length_decoder_defines.svh.
//
// The input channel carries items of two kinds. A feed item (opcode 0) pushes one
// encoded byte: a record is a big-endian repeat count of count_bytes bytes and then
// a symbol of symbol_bytes bytes. A read item (opcode 1) returns the next decoded
// byte. Every item gives exactly one result item on the output channel: feed
// accepted, feed refused while a run is still being read out, byte given (with
// last_of_run on the final byte of a run), or no data.
// A record with a zero count is dropped without starting a run.
// Both channels use valid and stall. An item is taken into the input register,
// decoded there against the running state, and its result is loaded into the
// output register at the first edge at which that register is empty or drained.
// One item is accepted per cycle while the receiver does not stall; the running state
// is updated as each item leaves the input register, so the next item sees it at once.
// When the receiver stalls, the output register holds its result and the input
// register keeps its item; input stall rises only while both are full.
// Reset clears the state, sets both size registers to one and empties both
// registers. The symbol bytes are not cleared. The user must write sizes through the
// configuration port only while the block is idle; the block does not enforce this.
`include "run_length_decoder_defines.svh"

module run_length_decoder
	import rld_pkg::*;
#(
	parameter int MAX_COUNT_BYTES  = DEF_MAX_COUNT_BYTES,
	parameter int MAX_SYMBOL_BYTES = DEF_MAX_SYMBOL_BYTES
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 opcode,
	input  logic [7:0]           encoded_byte,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [7:0]           out_byte,
	output logic [1:0]           status,
	output logic                 last_of_run
);

	localparam int ACC_W = 8 * MAX_COUNT_BYTES;
	localparam int HP_W  = $clog2(MAX_COUNT_BYTES + 1);
	localparam int SP_W  = (MAX_SYMBOL_BYTES > 1) ? $clog2(MAX_SYMBOL_BYTES) : 1;

	logic [CFG_W-1:0] count_bytes_q;
	logic [CFG_W-1:0] symbol_bytes_q;

	logic             valid_s1;
	opcode_t          opcode_s1;
	logic [7:0]       byte_s1;

	logic [ACC_W-1:0] count_accum_q;
	logic [HP_W-1:0]  header_pos_q;
	logic [7:0]       symbol_store_q [MAX_SYMBOL_BYTES];
	logic [ACC_W-1:0] repeats_left_q;
	logic [SP_W-1:0]  symbol_pos_q;
	logic             run_ready_q;

	logic             out_valid_q;
	logic [7:0]       out_byte_q;
	status_t          out_status_q;
	logic             out_last_q;

	logic             out_free;
	logic             advance;
	logic             fire;
	logic             plain_res;

	logic [SIZE_W-1:0] cb;
	logic [SIZE_W-1:0] sb;
	logic [SIZE_W-1:0] sp_ext;
	logic [SIZE_W-1:0] rd_next;
	logic [SP_W-1:0]   rd_pos;
	logic [ACC_W-1:0]  rep_dec;

	logic [ACC_W-1:0] count_accum_d;
	logic [HP_W-1:0]  header_pos_d;
	logic [ACC_W-1:0] repeats_left_d;
	logic [SP_W-1:0]  symbol_pos_d;
	logic             run_ready_d;
	logic             store_we;
	logic [7:0]       res_byte;
	status_t          res_status;
	logic             res_last;

	assign out_free = !out_valid_q || !out_stall;
	assign advance  = !valid_s1 || out_free;
	assign fire     = valid_s1 && out_free;
	assign in_stall = !advance;

	assign out_valid   = out_valid_q;
	assign out_byte    = out_byte_q;
	assign status      = out_status_q;
	assign last_of_run = out_last_q;

	assign plain_res = out_valid_q && (out_status_q != ST_BYTE);

	assign cb      = clamp_size(count_bytes_q, MAX_COUNT_BYTES);
	assign sb      = clamp_size(symbol_bytes_q, MAX_SYMBOL_BYTES);
	assign sp_ext  = SIZE_W'(symbol_pos_q);
	assign rd_pos  = (sp_ext >= sb) ? '0 : symbol_pos_q;
	assign rd_next = SIZE_W'(rd_pos) + SIZE_W'(1);
	assign rep_dec = repeats_left_q - ACC_W'(1);

	always_comb begin
		count_accum_d  = count_accum_q;
		header_pos_d   = header_pos_q;
		repeats_left_d = repeats_left_q;
		symbol_pos_d   = symbol_pos_q;
		run_ready_d    = run_ready_q;
		store_we       = 1'b0;
		res_byte       = '0;
		res_status     = ST_ACCEPTED;
		res_last       = 1'b0;
		case (opcode_s1)
			OP_FEED: begin
				if (run_ready_q) begin
					res_status = ST_REFUSED;
				end else if (SIZE_W'(header_pos_q) < cb) begin
					count_accum_d = ACC_W'({count_accum_q, byte_s1});
					header_pos_d  = header_pos_q + HP_W'(1);
				end else begin
					store_we = (sp_ext < SIZE_W'(MAX_SYMBOL_BYTES));
					if (sp_ext + SIZE_W'(1) >= sb) begin
						if (count_accum_q != '0) begin
							repeats_left_d = count_accum_q;
							run_ready_d    = 1'b1;
						end
						count_accum_d = '0;
						header_pos_d  = '0;
						symbol_pos_d  = '0;
					end else begin
						symbol_pos_d = symbol_pos_q + SP_W'(1);
					end
				end
			end
			OP_READ: begin
				if (!run_ready_q) begin
					res_status = ST_NODATA;
				end else begin
					res_status = ST_BYTE;
					res_byte   = symbol_store_q[rd_pos];
					if (rd_next >= sb) begin
						symbol_pos_d   = '0;
						repeats_left_d = rep_dec;
						if (rep_dec == '0) begin
							run_ready_d = 1'b0;
							res_last    = 1'b1;
						end
					end else begin
						symbol_pos_d = SP_W'(rd_next);
					end
				end
			end
			default: begin
				res_status = ST_NODATA;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_bytes_q  <= CFG_W'(1);
			symbol_bytes_q <= CFG_W'(1);
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_COUNT_BYTES:  count_bytes_q  <= cfg_data;
				REG_SYMBOL_BYTES: symbol_bytes_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && in_valid) begin
			opcode_s1 <= opcode_t'(opcode);
			byte_s1   <= encoded_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_accum_q  <= '0;
			header_pos_q   <= '0;
			repeats_left_q <= '0;
			symbol_pos_q   <= '0;
			run_ready_q    <= 1'b0;
		end else if (fire) begin
			count_accum_q  <= count_accum_d;
			header_pos_q   <= header_pos_d;
			repeats_left_q <= repeats_left_d;
			symbol_pos_q   <= symbol_pos_d;
			run_ready_q    <= run_ready_d;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && store_we) begin
			symbol_store_q[symbol_pos_q] <= byte_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_byte_q   <= res_byte;
			out_status_q <= res_status;
			out_last_q   <= res_last;
		end
	end

	`RLD_ASSERT(a_run_reps, !run_ready_q || (repeats_left_q != '0), "run without repeats")
	`RLD_ASSERT_IMPL(a_stall_full, in_stall, valid_s1 && out_valid_q && out_stall, "bad stall")
	`RLD_ASSERT_IMPL(a_last_ends_run, $past(fire) && out_last_q, !run_ready_q, "run still open")
	`RLD_ASSERT_IMPL(a_plain_clean, plain_res, {out_byte_q, out_last_q} == '0, "stray data")
	`RLD_ASSERT(a_hdr_range, SIZE_W'(header_pos_q) <= SIZE_W'(MAX_COUNT_BYTES), "overrun")

endmodule

@@ sim/tb.sv @@
// Self-checking testbench for run_length_decoder: a directed table, then random record streams.
// Depends on rld_pkg and run_length_decoder; expected results: local decoder or typed table rows.
module tb;
	import rld_pkg::*;

	localparam int unsigned CNT_MAX = DEF_MAX_COUNT_BYTES;
	localparam int unsigned SYM_MAX = DEF_MAX_SYMBOL_BYTES;
	localparam int unsigned LIMIT = 400000;
	localparam int unsigned PHASES = 14;
	localparam int unsigned PHASE_ITEMS = 125;
	localparam int NUM_ROWS = 40;

	typedef struct packed {
		logic [7:0] data;
		status_t    st;
		logic       last;
	} outcome_t;

	typedef enum logic {
		ROW_ITEM,
		ROW_CFG
	} row_kind_t;

	typedef struct packed {
		row_kind_t            kind;
		opcode_t              op;
		logic [7:0]           val;
		logic [CFG_IDX_W-1:0] reg_idx;
		logic                 typed;
		status_t              st;
		logic [7:0]           data;
		logic                 last;
	} row_t;

	row_t dir_rows [NUM_ROWS] = '{
		'{ROW_ITEM, OP_READ, 8'h00, REG_COUNT_BYTES, 1'b1, ST_NODATA, 8'h00, 1'b0},
		'{ROW_ITEM, OP_FEED, 8'h00, REG_COUNT_BYTES, 1'b0, ST_ACCEPTED, 8'h00, 1'b0},
		'{ROW_ITEM, OP_FEED, 8'hFF, REG_COUNT_BYTES, 1'b0, ST_ACCEPTED, 8'h00, 1'b0},
		'{ROW_ITEM, OP_READ, 8'h00, REG_COUNT_BYTES, 1'b1, ST_NODATA, 8'h00, 1'b0},
		'{ROW_ITEM, OP_FEED, 8'h02, REG_COUNT_BYTES, 1'b0, ST_ACCEPTED, 8'h00, 1'b0},
		'{ROW_ITEM, OP_FEED, 8'hA5, REG_COUNT_BYTES, 1'b0, ST_ACCEPTED, 8'h00, 1'b0},
		'{ROW_ITEM, OP_FEED, 8'h11, REG_COUNT_BYTES, 1'b1, ST_REFUSED, 8'h00, 1'b0},
		'{ROW_ITEM, OP_READ, 8'h00, REG_COUNT_BYTES, 1'b1, ST_BYTE, 8'hA5, 1'b0},
		'{ROW_ITEM, OP_READ, 8'hFF, REG_COUNT_BYTES, 1'b1, ST_BYTE, 8'hA5, 1'b1},
		'{ROW_ITEM, OP_READ, 8'h00, REG_COUNT_BYTES, 1'b1, ST_NODATA, 8'h00, 1'b0},
		'{ROW_ITEM, OP_FEED, 8'h01, REG_COUNT_BYTES, 1'b0, ST_ACCEPTED, 8'h00, 1'b0},
		'{ROW_ITEM, OP_FEED, 8'hFF, REG_COUNT_BYTES, 1'b0, ST_ACCEPTED, 8'h00, 1'b0},
		'{ROW_ITEM, OP_READ, 8'h00, REG_COUNT_BYTES, 1'b1, ST_BYTE, 8'hFF, 1'b1},
		'{ROW_CFG, OP_FEED, 8'h07, REG_COUNT_BYTES, 1'b0, ST_ACCEPTED, 8'h00, 1'b0},
		'{ROW_CFG, OP_FEED, 8'h06, REG_SYMBOL_BYTES, 1'b0, ST_ACCEPTED, 8'h00, 1'b0},
		'{ROW_ITEM, OP_FEED, 8'h00, REG_COUNT_BYTES, 1'b0, ST_ACCEPTED, 8'h00, 1'b0},
		'{ROW_ITEM, OP_FEED, 8'h00, REG_COUNT_BYTES, 1'b0, ST_ACCEPTED, 8'h00, 1'b0},
		'{ROW_ITEM, OP_FEED, 8'h00, REG_COUNT_BYTES, 1'b0, ST_ACCEPTED, 8'h00, 1'b0},
		'{ROW_ITEM, OP_FEED, 8'h01, REG_COUNT_BYTES, 1'b0, ST_ACCEPTED, 8'h00, 1'b0},
		'{ROW_ITEM, OP_FEED, 8'h00, REG_COUNT_BYTES, 1'b0, ST_ACCEPTED, 8'h00, 1'b0},
		'{ROW_ITEM, OP_FEED, 8'h12, REG_COUNT_BYTES, 1'b0, ST_ACCEPTED, 8'h00, 1'b0},
		'{ROW_ITEM, OP_FEED, 8'h34, REG_COUNT_BYTES, 1'b0, ST_ACCEPTED, 8'h00, 1'b0},
		'{ROW_ITEM, OP_FEED, 8'hFF, REG_COUNT_BYTES, 1'b0, ST_ACCEPTED, 8'h00, 1'b0},
		'{ROW_ITEM, OP_READ, 8'h00, REG_COUNT_BYTES, 1'b0, ST_ACCEPTED, 8'h00, 1'b0},
		'{ROW_ITEM, OP_READ, 8'h00, REG_COUNT_BYTES, 1'b0, ST_ACCEPTED, 8'h00, 1'b0},
		'{ROW_ITEM, OP_READ, 8'h00, REG_COUNT_BYTES, 1'b0, ST_ACCEPTED, 8'h00, 1'b0},
		'{ROW_ITEM, OP_READ, 8'h00, REG_COUNT_BYTES, 1'b0, ST_ACCEPTED, 8'h00, 1'b0},
		'{ROW_ITEM, OP_READ, 8'h00, REG_COUNT_BYTES, 1'b1, ST_NODATA, 8'h00, 1'b0},
		'{ROW_CFG, OP_FEED, 8'h04, REG_COUNT_BYTES, 1'b0, ST_ACCEPTED, 8'h00, 1'b0},
		'{ROW_ITEM, OP_FEED, 8'h00, REG_COUNT_BYTES, 1'b0, ST_ACCEPTED, 8'h00, 1'b0},
		'{ROW_ITEM, OP_FEED, 8'h02, REG_COUNT_BYTES, 1'b0, ST_ACCEPTED, 8'h00, 1'b0},
		'{ROW_CFG, OP_FEED, 8'h00, REG_COUNT_BYTES, 1'b0, ST_ACCEPTED, 8'h00, 1'b0},
		'{ROW_CFG, OP_FEED, 8'h02, REG_SYMBOL_BYTES, 1'b0, ST_ACCEPTED, 8'h00, 1'b0},
		'{ROW_ITEM, OP_FEED, 8'hAA, REG_COUNT_BYTES, 1'b0, ST_ACCEPTED, 8'h00, 1'b0},
		'{ROW_ITEM, OP_FEED, 8'hBB, REG_COUNT_BYTES, 1'b0, ST_ACCEPTED, 8'h00, 1'b0},
		'{ROW_ITEM, OP_READ, 8'h00, REG_COUNT_BYTES, 1'b0, ST_ACCEPTED, 8'h00, 1'b0},
		'{ROW_CFG, OP_FEED, 8'h01, REG_SYMBOL_BYTES, 1'b0, ST_ACCEPTED, 8'h00, 1'b0},
		'{ROW_ITEM, OP_READ, 8'h00, REG_COUNT_BYTES, 1'b0, ST_ACCEPTED, 8'h00, 1'b0},
		'{ROW_ITEM, OP_READ, 8'h00, REG_COUNT_BYTES, 1'b0, ST_ACCEPTED, 8'h00, 1'b0},
		'{ROW_ITEM, OP_READ, 8'h00, REG_COUNT_BYTES, 1'b1, ST_NODATA, 8'h00, 1'b0}
	};

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_COUNT_BYTES;
	logic [CFG_W-1:0]     cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic                 opcode = OP_FEED;
	logic [7:0]           encoded_byte = 8'h00;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [7:0]           out_byte;
	logic [1:0]           status;
	logic                 last_of_run;

	logic [2:0]  cnt_size;
	logic [2:0]  sym_size;
	logic [31:0] count_sum;
	int unsigned hdr_pos;
	logic [7:0]  sym_store [SYM_MAX];
	logic [31:0] reps_left;
	int unsigned sym_pos;
	logic        run_pending;
	int unsigned sym_filled;

	outcome_t    outcome_q [$];
	outcome_t    head;
	int unsigned n_errors = 0;
	int unsigned n_items = 0;
	int unsigned n_given = 0;
	int unsigned n_runs = 0;
	int unsigned n_refused = 0;
	int unsigned n_nodata = 0;
	int unsigned n_cfg = 0;
	int unsigned cycle_cnt = 0;

	run_length_decoder uut (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
	end

	initial begin
		wait (cycle_cnt >= LIMIT);
		$display("Verification failed");
		$finish;
	end

	function automatic int unsigned eff_size(logic [2:0] v, int unsigned lim);
		if (v == 3'd0) begin
			return 1;
		end
		return (v > lim) ? lim : int'(v);
	endfunction

	function automatic outcome_t decode_step(opcode_t op, logic [7:0] b);
		outcome_t    r;
		int unsigned cb;
		int unsigned sb;
		cb = eff_size(cnt_size, CNT_MAX);
		sb = eff_size(sym_size, SYM_MAX);
		r = '{data: 8'h00, st: ST_ACCEPTED, last: 1'b0};
		if (op == OP_FEED) begin
			if (run_pending) begin
				r.st = ST_REFUSED;
			end else if (hdr_pos < cb) begin
				count_sum = {count_sum[23:0], b};
				hdr_pos++;
			end else begin
				sym_store[sym_pos] = b;
				if (sym_pos + 1 > sym_filled) begin
					sym_filled = sym_pos + 1;
				end
				if (sym_pos + 1 >= sb) begin
					if (count_sum != 0) begin
						reps_left = count_sum;
						run_pending = 1'b1;
					end
					count_sum = '0;
					hdr_pos = 0;
					sym_pos = 0;
				end else begin
					sym_pos++;
				end
			end
		end else if (!run_pending) begin
			r.st = ST_NODATA;
		end else begin
			if (sym_pos >= sb) begin
				sym_pos = 0;
			end
			r.data = sym_store[sym_pos];
			r.st = ST_BYTE;
			sym_pos++;
			if (sym_pos >= sb) begin
				sym_pos = 0;
				reps_left--;
				if (reps_left == 0) begin
					run_pending = 1'b0;
					r.last = 1'b1;
				end
			end
		end
		return r;
	endfunction

	task automatic send_item(opcode_t op, logic [7:0] b, logic typed, outcome_t typed_res);
		outcome_t r;
		in_valid <= 1'b1;
		opcode <= op;
		encoded_byte <= b;
		do @(posedge clk); while (in_stall);
		r = decode_step(op, b);
		outcome_q.push_back(typed ? typed_res : r);
		n_items++;
		case (r.st)
			ST_BYTE: begin
				n_given++;
				n_runs += r.last;
			end
			ST_REFUSED: n_refused++;
			ST_NODATA: n_nodata++;
			default: ;
		endcase
	endtask

	task automatic idle(int unsigned n);
		in_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		do @(posedge clk); while (outcome_q.size() != 0);
	endtask

	task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [2:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		if (idx == REG_COUNT_BYTES) begin
			cnt_size = val;
		end else begin
			sym_size = val;
		end
		n_cfg++;
		@(posedge clk);
	endtask

	initial begin
		int unsigned ph;
		int unsigned k;
		int unsigned gap;
		int unsigned burst_left;
		int unsigned cb_eff;
		int unsigned sel;
		logic [2:0]  new_cb;
		logic [2:0]  new_sb;
		opcode_t     nop;
		logic [7:0]  nb;
		outcome_t    typed_res;

		cnt_size = 3'd1;
		sym_size = 3'd1;
		count_sum = '0;
		hdr_pos = 0;
		reps_left = '0;
		sym_pos = 0;
		run_pending = 1'b0;
		sym_filled = 0;
		foreach (sym_store[i]) begin
			sym_store[i] = 8'h00;
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_CFG) begin
				wait_idle();
				write_cfg(dir_rows[i].reg_idx, dir_rows[i].val[2:0]);
			end else begin
				typed_res = '{data: dir_rows[i].data, st: dir_rows[i].st,
					last: dir_rows[i].last};
				send_item(dir_rows[i].op, dir_rows[i].val, dir_rows[i].typed, typed_res);
				gap = $urandom_range(0, 2);
				if (gap != 0) begin
					idle(gap);
				end
			end
		end

		burst_left = 0;
		for (ph = 0; ph < PHASES; ph++) begin
			wait_idle();
			new_cb = 3'($urandom_range(0, 7));
			new_sb = 3'($urandom_range(0, 7));
			// A pending run must not be widened onto symbol bytes that were never loaded.
			if (run_pending && eff_size(new_sb, SYM_MAX) > sym_filled) begin
				new_sb = 3'(sym_filled);
			end
			write_cfg(REG_COUNT_BYTES, new_cb);
			write_cfg(REG_SYMBOL_BYTES, new_sb);
			for (k = 0; k < PHASE_ITEMS; k++) begin
				if (burst_left == 0) begin
					idle($urandom_range(1, 8));
					burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
						: $urandom_range(1, 10);
				end
				burst_left--;
				cb_eff = eff_size(cnt_size, CNT_MAX);
				nb = 8'($urandom_range(0, 255));
				if (run_pending) begin
					nop = ($urandom_range(0, 9) == 0) ? OP_FEED : OP_READ;
				end else if ($urandom_range(0, 9) == 0) begin
					nop = OP_READ;
				end else begin
					nop = OP_FEED;
					if (hdr_pos + 1 < cb_eff) begin
						nb = 8'h00;
					end else if (hdr_pos < cb_eff) begin
						sel = $urandom_range(0, 19);
						if (sel < 2) begin
							nb = 8'h00;
						end else if (sel == 2) begin
							nb = 8'($urandom_range(7, 40));
						end else begin
							nb = 8'($urandom_range(1, 5));
						end
					end
				end
				send_item(nop, nb, 1'b0, typed_res);
			end
		end

		wait_idle();
		repeat (8) @(posedge clk);
		$display("%0d items: %0d bytes given, %0d runs ended, %0d feeds refused,",
			n_items, n_given, n_runs, n_refused);
		$display("%0d empty reads, %0d size register writes, %0d mismatches.",
			n_nodata, n_cfg, n_errors);
		if (n_errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	initial begin
		int seg;
		int len;
		int mode;
		int hold;
		seg = 0;
		wait (arst_n);
		forever begin
			seg++;
			if (seg == 12 || seg == 30) begin
				for (hold = 0; hold < 120; hold++) begin
					@(posedge clk);
					out_stall <= 1'b1;
				end
			end else begin
				mode = $urandom_range(0, 3);
				len = $urandom_range(10, 60);
				repeat (len) begin
					@(posedge clk);
					case (mode)
						0: out_stall <= 1'b0;
						1: out_stall <= ($urandom_range(0, 3) == 0);
						2: out_stall <= ($urandom_range(0, 3) != 0);
						default: out_stall <= ~out_stall;
					endcase
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (outcome_q.size() == 0) begin
				n_errors++;
				$display("%0t: unexpected item, status %0d byte %02h last %0d",
					$time, status, out_byte, last_of_run);
			end else begin
				head = outcome_q.pop_front();
				if (status !== head.st) begin
					n_errors++;
					$display("%0t: status expected %0d, actual %0d", $time, head.st, status);
				end
				if (out_byte !== head.data) begin
					n_errors++;
					$display("%0t: out_byte expected %02h, actual %02h",
						$time, head.data, out_byte);
				end
				if (last_of_run !== head.last) begin
					n_errors++;
					$display("%0t: last_of_run expected %0d, actual %0d",
						$time, head.last, last_of_run);
				end
			end
		end
	end

endmodule
